### hw/rtl/ssmd_pkg.sv
package ssmd_pkg;

  // Command codes carried by an input item
  typedef enum logic [2:0] {
    CMD_REFRESH = 3'd0,
    CMD_WR_BYTE = 3'd1,
    CMD_NUMBER  = 3'd2,
    CMD_WR_FOUR = 3'd3,
    CMD_DOTS    = 3'd4
  } ssmd_cmd_code_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NUM,
    ST_SEG,
    ST_SEL
  } ssmd_state_t;

  // Strobes from controller to datapath
  typedef struct packed {
    logic do_refresh;
    logic do_wr_byte;
    logic do_wr_four;
    logic do_dots;
    logic do_num_start;
    logic do_num_step;
    logic do_num_commit;
    logic emit_seg;
    logic emit_sel;
  } ssmd_ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic num_done;
    logic last_module;
    logic out_free;
  } ssmd_stat_t;

  localparam int          WR_SPAN  = 32;        // addresses reachable by a byte write
  localparam logic [13:0] NUM_CAP  = 14'd9999;
  localparam logic [7:0]  DOT_MASK = 8'h80;

  // Segment pattern of a decimal digit, bit 0 is segment A
  function automatic logic [7:0] seg_font(input logic [3:0] d);
    logic [7:0] f;
    case (d)
      4'd0:    f = 8'h3F;
      4'd1:    f = 8'h06;
      4'd2:    f = 8'h5B;
      4'd3:    f = 8'h4F;
      4'd4:    f = 8'h66;
      4'd5:    f = 8'h6D;
      4'd6:    f = 8'h7D;
      4'd7:    f = 8'h07;
      4'd8:    f = 8'h7F;
      4'd9:    f = 8'h6F;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

  // Place value subtracted at each step of the decimal conversion
  function automatic logic [13:0] digit_weight(input logic [1:0] k);
    logic [13:0] w;
    case (k)
      2'd0:    w = 14'd1000;
      2'd1:    w = 14'd100;
      default: w = 14'd10;
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/ssmd_ctrl.sv
module ssmd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [2:0]          in_cmd,
  input  ssmd_pkg::ssmd_stat_t stat,
  output logic                in_stall,
  output ssmd_pkg::ssmd_ctrl_t ctrl
);
  import ssmd_pkg::*;

  ssmd_state_t state_r, state_nxt;
  logic        accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && ssmd_cmd_code_t'(in_cmd) == CMD_REFRESH) state_nxt = ST_SEG;
        if (accept && ssmd_cmd_code_t'(in_cmd) == CMD_NUMBER)  state_nxt = ST_NUM;
      end
      ST_NUM: begin
        if (stat.num_done) state_nxt = ST_IDLE;
      end
      ST_SEG: begin
        if (stat.out_free) state_nxt = ST_SEL;
      end
      ST_SEL: begin
        if (stat.out_free) state_nxt = stat.last_module ? ST_IDLE : ST_SEG;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath strobes
  always_comb begin
    ctrl = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (ssmd_cmd_code_t'(in_cmd))
            CMD_REFRESH: ctrl.do_refresh   = 1'b1;
            CMD_WR_BYTE: ctrl.do_wr_byte   = 1'b1;
            CMD_NUMBER:  ctrl.do_num_start = 1'b1;
            CMD_WR_FOUR: ctrl.do_wr_four   = 1'b1;
            CMD_DOTS:    ctrl.do_dots      = 1'b1;
            default:     ctrl = '0;
          endcase
        end
      end
      ST_NUM: begin
        if (stat.num_done) ctrl.do_num_commit = 1'b1;
        else               ctrl.do_num_step   = 1'b1;
      end
      ST_SEG:  ctrl.emit_seg = stat.out_free;
      ST_SEL:  ctrl.emit_sel = stat.out_free;
      default: ctrl = '0;
    endcase
  end

endmodule

### hw/rtl/ssmd_dpath.sv
module ssmd_dpath #(
  parameter int MAX_MODULES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ssmd_pkg::ssmd_ctrl_t ctrl,
  output ssmd_pkg::ssmd_stat_t stat,
  input  logic [4:0]           in_store_index,
  input  logic [7:0]           in_segment_value,
  input  logic [31:0]          in_number_value,
  input  logic [31:0]          in_packed_bytes,
  input  logic                 in_dots_on,
  input  logic                 cfg_wr_en,
  input  logic [3:0]           cfg_wr_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_wire_byte,
  output logic                 out_latch_after
);
  import ssmd_pkg::*;

  // Only the first WR_DEPTH bytes can ever be written; the rest read as blank
  localparam int STORE_DEPTH = 4 * MAX_MODULES;
  localparam int WR_DEPTH    = (STORE_DEPTH < WR_SPAN) ? STORE_DEPTH : WR_SPAN;
  localparam int IW          = $clog2(WR_DEPTH);
  localparam int MW          = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;

  logic [7:0]    store_r [WR_DEPTH];
  logic [3:0]    mod_cnt_r;
  logic [1:0]    digit_r;
  logic [MW-1:0] row_r;
  logic [MW-1:0] last_row;
  logic [MW+1:0] rd_idx;
  logic [7:0]    rd_byte;

  logic [13:0]   num_sat;
  logic [13:0]   rem_r;
  logic [13:0]   weight;
  logic [1:0]    k_r;
  logic [3:0]    cnt_r;
  logic [3:0]    thou_r, hund_r;
  logic          gt9_r, gt99_r, gt999_r;
  logic          rem_ge;

  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_latch_r;

  assign out_valid       = out_valid_r;
  assign out_wire_byte   = out_byte_r;
  assign out_latch_after = out_latch_r;

  // Module count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_cnt_r <= 4'd1;
    end else if (cfg_wr_en) begin
      mod_cnt_r <= cfg_wr_data;
    end
  end

  // Highest module row, count clamped to 1..MAX_MODULES
  always_comb begin
    if (mod_cnt_r == 4'd0) begin
      last_row = '0;
    end else if (int'(mod_cnt_r) > MAX_MODULES) begin
      last_row = MW'(MAX_MODULES - 1);
    end else begin
      last_row = MW'(int'(mod_cnt_r) - 1);
    end
  end

  // Store read for the refresh: row counts down, byte within row is 3 - digit
  assign rd_idx  = {row_r, ~digit_r};
  assign rd_byte = (int'(rd_idx) < WR_DEPTH) ? store_r[rd_idx[IW-1:0]] : 8'h00;

  // Decimal conversion by repeated subtraction of place values
  assign num_sat = (in_number_value > 32'(NUM_CAP)) ? NUM_CAP : in_number_value[13:0];
  assign weight  = digit_weight(k_r);
  assign rem_ge  = (rem_r >= weight);

  always_ff @(posedge clk) begin
    if (ctrl.do_num_start) begin
      rem_r   <= num_sat;
      k_r     <= 2'd0;
      cnt_r   <= 4'd0;
      gt9_r   <= (num_sat > 14'd9);
      gt99_r  <= (num_sat > 14'd99);
      gt999_r <= (num_sat > 14'd999);
    end else if (ctrl.do_num_step) begin
      if (rem_ge) begin
        rem_r <= rem_r - weight;
        cnt_r <= cnt_r + 4'd1;
      end else begin
        if (k_r == 2'd0) thou_r <= cnt_r;
        else             hund_r <= cnt_r;
        cnt_r <= 4'd0;
        k_r   <= k_r + 2'd1;
      end
    end
  end

  // Segment store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WR_DEPTH; i++) store_r[i] <= 8'h00;
    end else if (ctrl.do_wr_byte) begin
      if (int'(in_store_index) < WR_DEPTH) store_r[in_store_index[IW-1:0]] <= in_segment_value;
    end else if (ctrl.do_wr_four) begin
      for (int k = 0; k < 4; k++) store_r[k] <= in_packed_bytes[8*k +: 8];
    end else if (ctrl.do_dots) begin
      for (int k = 0; k < 4; k++) begin
        store_r[k] <= in_dots_on ? (store_r[k] | DOT_MASK) : (store_r[k] & ~DOT_MASK);
      end
    end else if (ctrl.do_num_commit) begin
      // leading zeros stay blank
      store_r[0] <= gt999_r ? seg_font(thou_r) : 8'h00;
      store_r[1] <= gt99_r  ? seg_font(hund_r) : 8'h00;
      store_r[2] <= gt9_r   ? seg_font(cnt_r)  : 8'h00;
      store_r[3] <= seg_font(rem_r[3:0]);
    end
  end

  // Digit counter and module row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= 2'd0;
    end else if (ctrl.do_refresh) begin
      digit_r <= digit_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.do_refresh) begin
      row_r <= last_row;
    end else if (ctrl.emit_sel && row_r != '0) begin
      row_r <= row_r - MW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit_seg || ctrl.emit_sel) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_seg) begin
      out_byte_r  <= ~rd_byte;
      out_latch_r <= 1'b0;
    end else if (ctrl.emit_sel) begin
      out_byte_r  <= 8'b1 << digit_r;
      out_latch_r <= (row_r == '0);
    end
  end

  // Status
  always_comb begin
    stat.num_done    = (k_r == 2'd2) && !rem_ge;
    stat.last_module = (row_r == '0);
    stat.out_free    = !out_valid_r || !out_stall;
  end

endmodule

### hw/rtl/seven_segment_multiplex_driver_top.sv
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  cmd, store_index, segment_value, number_value,
//                                        packed_bytes, dots_on
// out_     output     out_valid/out_stall wire_byte, latch_after
// cfg_     input      cfg_wr_en          cfg_wr_data (module count)
//
// One item at a time. Store, four-byte and dot writes finish in the accepting cycle.
// Show number runs a subtract-per-cycle decimal conversion.
// A refresh emits 2 bytes per module, one per cycle while out_stall stays low.
// Synchronous active-low reset blanks the store, zeroes the digit and sets one module.
module seven_segment_multiplex_driver_top #(
  parameter int MAX_MODULES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [4:0]  in_store_index,
  input  logic [7:0]  in_segment_value,
  input  logic [31:0] in_number_value,
  input  logic [31:0] in_packed_bytes,
  input  logic        in_dots_on,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_wire_byte,
  output logic        out_latch_after,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);
  import ssmd_pkg::*;

  ssmd_ctrl_t ctrl;
  ssmd_stat_t stat;

  ssmd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .stat     (stat),
    .in_stall (in_stall),
    .ctrl     (ctrl)
  );

  ssmd_dpath #(
    .MAX_MODULES (MAX_MODULES)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .stat             (stat),
    .in_store_index   (in_store_index),
    .in_segment_value (in_segment_value),
    .in_number_value  (in_number_value),
    .in_packed_bytes  (in_packed_bytes),
    .in_dots_on       (in_dots_on),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_wire_byte    (out_wire_byte),
    .out_latch_after  (out_latch_after)
  );

  // A refresh item keeps the input side busy while bytes go out
  a_refresh_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_cmd == CMD_REFRESH) |=> in_stall)
    else $error("input taken during refresh");

  // Store updates other than show number finish in the accepting cycle
  a_quick_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_cmd != CMD_REFRESH && in_cmd != CMD_NUMBER) |=> !in_stall)
    else $error("single-cycle command left block busy");

  // The byte flagged for the latch is always a digit select
  a_latch_select: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_latch_after) |-> $onehot(out_wire_byte))
    else $error("latch flag on a non-select byte");

endmodule

### test/tb.sv
module tb;
  import ssmd_pkg::*;

  localparam int          MAX_MODULES = 8;
  localparam int          STORE_BYTES = 4 * MAX_MODULES;
  localparam logic [2:0]  CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  CMD_SPARE_LAST  = 3'd7;
  localparam int          IDLE_PERCENT = 19;
  localparam int          SETTLE_CYCLES = 40;   // longest number conversion plus margin
  localparam int          HOLD_CYCLES = 300;
  localparam int          CYCLE_LIMIT = 300000;

  // One input item
  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  store_index;
    logic [7:0]  segment_value;
    logic [31:0] number_value;
    logic [31:0] four_bytes;
    logic        dots_on;
  } disp_item_t;

  // One byte on the shift wire
  typedef struct packed {
    logic [7:0] wire_byte;
    logic       latch_after;
  } wire_beat_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_cmd;
  logic [4:0]  in_store_index;
  logic [7:0]  in_segment_value;
  logic [31:0] in_number_value;
  logic [31:0] in_packed_bytes;
  logic        in_dots_on;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_wire_byte;
  logic        out_latch_after;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;

  // Shadow of the block state
  logic [7:0]  shadow_store [STORE_BYTES];
  logic [1:0]  shadow_digit;
  logic [3:0]  shadow_modules;
  logic [7:0]  glyph_of [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

  wire_beat_t  pending_bytes [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;

  seven_segment_multiplex_driver_top #(.MAX_MODULES(MAX_MODULES)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_store_index   (in_store_index),
    .in_segment_value (in_segment_value),
    .in_number_value  (in_number_value),
    .in_packed_bytes  (in_packed_bytes),
    .in_dots_on       (in_dots_on),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_wire_byte    (out_wire_byte),
    .out_latch_after  (out_latch_after),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #6 clk = ~clk;

  function automatic bit take_break();
    return idle_on && ($urandom_range(99) < IDLE_PERCENT);
  endfunction

  // Refresh: advance the digit, then segment and select bytes per module
  task automatic predict_refresh();
    int n;
    int idx;
    n = (shadow_modules == 4'd0) ? 1 :
        (shadow_modules > MAX_MODULES) ? MAX_MODULES : int'(shadow_modules);
    shadow_digit = shadow_digit + 2'd1;
    for (int m = 0; m < n; m++) begin
      idx = 4 * n - 1 - int'(shadow_digit) - 4 * m;
      pending_bytes.push_back('{wire_byte: ~shadow_store[idx], latch_after: 1'b0});
      pending_bytes.push_back('{wire_byte: 8'(1 << shadow_digit), latch_after: (m == n - 1)});
    end
  endtask

  // Decimal display, saturated, leading zeros blank
  task automatic predict_number(input logic [31:0] num);
    int unsigned v;
    v = (num > 32'd9999) ? 9999 : num;
    shadow_store[0] = 8'h00;
    shadow_store[1] = 8'h00;
    shadow_store[2] = 8'h00;
    shadow_store[3] = glyph_of[v % 10];
    if (v > 9)   shadow_store[2] = glyph_of[(v / 10) % 10];
    if (v > 99)  shadow_store[1] = glyph_of[(v / 100) % 10];
    if (v > 999) shadow_store[0] = glyph_of[(v / 1000) % 10];
  endtask

  task automatic predict_item(input disp_item_t it);
    case (it.cmd)
      CMD_REFRESH: predict_refresh();
      CMD_WR_BYTE: shadow_store[it.store_index] = it.segment_value;
      CMD_NUMBER:  predict_number(it.number_value);
      CMD_WR_FOUR: for (int k = 0; k < 4; k++) shadow_store[k] = it.four_bytes[8 * k +: 8];
      CMD_DOTS:    for (int k = 0; k < 4; k++) shadow_store[k][7] = it.dots_on;
      default: ;
    endcase
  endtask

  // Random payload with the command forced; unused fields still toggle
  function automatic disp_item_t make_item(input logic [2:0] cmd);
    disp_item_t it;
    it.cmd           = cmd;
    it.store_index   = 5'($urandom);
    it.segment_value = 8'($urandom);
    it.number_value  = $urandom;
    it.four_bytes    = $urandom;
    it.dots_on       = 1'($urandom);
    return it;
  endfunction

  function automatic logic [31:0] pick_number();
    case ($urandom_range(3))
      0:       return $urandom_range(9);
      1:       return $urandom_range(9999);
      2:       return $urandom_range(10010, 9990);
      default: return $urandom;
    endcase
  endfunction

  // Offer one item, hold it until accepted, then predict
  task automatic send_item(input disp_item_t it);
    @(negedge clk);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= it.cmd;
    in_store_index   <= it.store_index;
    in_segment_value <= it.segment_value;
    in_number_value  <= it.number_value;
    in_packed_bytes  <= it.four_bytes;
    in_dots_on       <= it.dots_on;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    predict_item(it);
  endtask

  task automatic send_cmd(input logic [2:0] cmd);
    send_item(make_item(cmd));
  endtask

  // Drop valid, drain every expected byte, let a conversion finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_module_count(input logic [3:0] value);
    settle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 4'($urandom);
    shadow_modules = value;
  endtask

  // Reset contents, extremes of every command, spare codes
  task automatic test_directed();
    disp_item_t it;
    logic [31:0] nums [6] = '{32'd0, 32'd42, 32'd1000, 32'd9999, 32'd10000, 32'hFFFF_FFFF};
    send_cmd(CMD_REFRESH);
    it = make_item(CMD_WR_BYTE);
    it.store_index = 5'd0;  it.segment_value = 8'hFF; send_item(it);
    it.store_index = 5'd31; it.segment_value = 8'h00; send_item(it);
    it.store_index = 5'd3;  it.segment_value = 8'hA5; send_item(it);
    send_cmd(CMD_REFRESH);
    foreach (nums[i]) begin
      it = make_item(CMD_NUMBER);
      it.number_value = nums[i];
      send_item(it);
      if (i != 3) send_cmd(CMD_REFRESH);
    end
    it = make_item(CMD_WR_FOUR);
    it.four_bytes = 32'hFFFF_FFFF; send_item(it);
    send_cmd(CMD_REFRESH);
    it.four_bytes = 32'h0000_0000; send_item(it);
    it = make_item(CMD_DOTS);
    it.dots_on = 1'b1; send_item(it);
    send_cmd(CMD_REFRESH);
    it.dots_on = 1'b0; send_item(it);
    send_cmd(CMD_REFRESH);
    send_cmd(CMD_SPARE_FIRST);
    send_cmd(CMD_SPARE_LAST);
  endtask

  // Random command mix over several module counts
  task automatic test_random_mix();
    logic [3:0] counts [7];
    disp_item_t it;
    int pick;
    int sent;
    counts = '{4'd1, 4'd8, 4'd0, 4'd15, 4'($urandom_range(7, 2)), 4'd9, 4'($urandom)};
    foreach (counts[p]) begin
      write_module_count(counts[p]);
      idle_on = (p != 2);
      sent = 0;
      while (sent < 60) begin
        pick = $urandom_range(99);
        if (pick < 30)      it = make_item(CMD_REFRESH);
        else if (pick < 55) it = make_item(CMD_WR_BYTE);
        else if (pick < 72) it = make_item(CMD_NUMBER);
        else if (pick < 84) it = make_item(CMD_WR_FOUR);
        else if (pick < 94) it = make_item(CMD_DOTS);
        else it = make_item(3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)));
        if (it.cmd == CMD_NUMBER) it.number_value = pick_number();
        send_item(it);
        if (it.cmd <= CMD_DOTS) sent++;
      end
    end
    idle_on = 1'b1;
  endtask

  // Receiver holds off while refreshes keep coming
  task automatic test_backpressure();
    write_module_count(4'd8);
    hold_req = 1'b1;
    repeat (12) send_cmd(CMD_REFRESH);
  endtask

  // Receiver: random stalls, or one long hold when asked
  initial begin
    int hold_count;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        hold_count = 0;
        while (hold_count < HOLD_CYCLES) begin
          @(negedge clk);
          hold_count++;
        end
        hold_req = 1'b0;
      end else begin
        out_stall <= take_break();
      end
    end
  end

  // Compare each accepted byte with the oldest expectation
  always @(posedge clk) begin
    wire_beat_t exp_beat;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected item: wire_byte %h latch_after %b", out_wire_byte, out_latch_after);
        mismatch_count++;
      end else begin
        exp_beat = pending_bytes.pop_front();
        if (out_wire_byte !== exp_beat.wire_byte) begin
          $error("wire_byte: expected %h, actual %h", exp_beat.wire_byte, out_wire_byte);
          mismatch_count++;
        end
        if (out_latch_after !== exp_beat.latch_after) begin
          $error("latch_after: expected %b, actual %b", exp_beat.latch_after, out_latch_after);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_cmd           = CMD_REFRESH;
    in_store_index   = '0;
    in_segment_value = '0;
    in_number_value  = '0;
    in_packed_bytes  = '0;
    in_dots_on       = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    shadow_digit   = 2'd0;
    shadow_modules = 4'd1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_mix();
    test_backpressure();
    settle();

    if (mismatch_count == 0 && pending_bytes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
